### rtl/kphm_pkg.sv
// keyed pair hash map: shared types, constants and hash function
// no dependencies
`default_nettype none
package kphm_pkg;
   localparam int BUCKET_COUNT = 64;
   localparam int POOL_ENTRIES = 256;
   localparam int HASH_SHIFT = 4;
   localparam int BW = (BUCKET_COUNT > 1) ? $clog2(BUCKET_COUNT) : 1;
   localparam int IW = $clog2(POOL_ENTRIES + 1);
   localparam int AW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
   localparam logic [IW-1:0] NIL_INDEX = IW'(POOL_ENTRIES);

   localparam logic [1:0] KIND_LOOKUP = 2'd0;
   localparam logic [1:0] KIND_SET = 2'd1;
   localparam logic [1:0] KIND_CLEAR = 2'd2;
   localparam logic [1:0] KIND_NOP = 2'd3;
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_NO_ROOM = 2'd2;

   typedef struct packed {
      logic [1:0] kind;
      logic [63:0] key;
      logic [63:0] first_value;
      logic [63:0] second_value;
   } req_word_type;

   typedef struct packed {
      logic [1:0] status;
      logic found;
      logic [63:0] first_out;
      logic [63:0] second_out;
   } rsp_word_type;

   typedef struct packed {
      logic [63:0] key;
      logic [63:0] first;
      logic [63:0] second;
      logic [IW-1:0] link;
   } entry_type;

   function automatic logic [BW-1:0] bucket_of(input logic [63:0] key);
      logic [63:0] s;
      s = key >> HASH_SHIFT;
      if (BUCKET_COUNT == 1) return '0;
      return BW'(s % 64'(BUCKET_COUNT));
   endfunction
endpackage
`default_nettype wire

### rtl/kphm_pool.sv
// keyed pair hash map: entry pool memory, one write and one registered read port
// depends on kphm_pkg
`default_nettype none
module kphm_pool
   import kphm_pkg::*;
(
   input wire logic clock,
   input wire logic rd_en,
   input wire logic [AW-1:0] rd_addr,
   output entry_type rd_data,
   input wire logic wr_en,
   input wire logic [AW-1:0] wr_addr,
   input entry_type wr_data
);
   entry_type mem [POOL_ENTRIES];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

### rtl/kphm_heads.sv
// keyed pair hash map: bucket head memory with epoch marks, so clear empties every bucket without a memory sweep
// depends on kphm_pkg
`default_nettype none
module kphm_heads
   import kphm_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic clear,
   input wire logic [BW-1:0] rd_addr,
   output logic [IW-1:0] rd_data,
   input wire logic wr_en,
   input wire logic [BW-1:0] wr_addr,
   input wire logic [IW-1:0] wr_data
);
   logic [IW:0] mem [BUCKET_COUNT];
   logic epoch_ff, epoch_in;
   logic [IW:0] raw_ff;
   assign epoch_in = clear ? ~epoch_ff : epoch_ff;
   always_ff @(posedge clock) begin
      if (reset) epoch_ff <= 1'b0;
      else epoch_ff <= epoch_in;
   end
   // entries carry their epoch; a stale epoch reads as empty
   // reset leaves memory unknown, so a per-bucket valid vector backs it up
   logic [BUCKET_COUNT-1:0] valid_ff;
   always_ff @(posedge clock) begin
      if (reset || clear) valid_ff <= '0;
      else if (wr_en) valid_ff[wr_addr] <= 1'b1;
   end
   logic vld_ff;
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= {epoch_ff, wr_data};
      raw_ff <= mem[rd_addr];
      vld_ff <= valid_ff[rd_addr] && !clear && !reset;
   end
   assign rd_data = (vld_ff && raw_ff[IW] == epoch_ff) ? raw_ff[IW-1:0] : NIL_INDEX;
endmodule
`default_nettype wire

### rtl/keyed_pair_hash_map_top.sv
// keyed pair hash map: top level, control sequencer walking bucket chains
// depends on kphm_pkg, kphm_pool, kphm_heads
`default_nettype none
// usage:
//   the request word (kind, key, first_value, second_value) is taken at a
//   clock edge with start high and busy low. busy stays high while the op
//   runs. one response word per request appears on rsp_word for a single
//   cycle with rsp_strobe high; the receiver cannot hold it off.
//   clear, kind 3 and zero keys go straight to the response. a lookup reads
//   the bucket head, then walks the chain. a set then updates the entry,
//   deletes it, inserts a fresh entry or one from the free list, or reports
//   no room when the pool is full. a new word can be taken in the strobe
//   cycle, but not while busy; the chain walk through the pool memory does
//   one registered read per entry.
//   reset: synchronous, active high; empties every bucket, free list and
//   fresh counter. clear does the same via epoch marks.
//   pool entries are not cleared; they are reached only after being written.
module keyed_pair_hash_map_top
   import kphm_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   output logic busy,
   input req_word_type req_word,
   output logic rsp_strobe,
   output rsp_word_type rsp_word
);
   localparam logic [2:0] S_IDLE = 3'd0, S_HEAD = 3'd1, S_READ = 3'd2, S_CHECK = 3'd3,
      S_FREE = 3'd4, S_WRITE = 3'd5, S_DONE = 3'd6;

   logic [2:0] state_ff, state_in;
   req_word_type req_ff;
   logic [BW-1:0] bkt_ff;
   logic [IW-1:0] cur_ff, cur_in, prev_ff, prev_in;
   entry_type cur_e_ff, cur_e_in, prev_e_ff, prev_e_in;
   logic [IW-1:0] free_ff, free_in;
   logic [IW-1:0] fresh_ff, fresh_in;
   logic [IW-1:0] head_q;
   rsp_word_type rsp_ff, rsp_in;
   logic strobe_ff;
   // bucket head as seen at the start of this op
   logic [IW-1:0] bhead_ff;

   logic p_rd_en, p_wr_en;
   logic [AW-1:0] p_rd_addr, p_wr_addr;
   entry_type p_rd_data, p_wr_data;
   logic h_wr_en, h_clear;
   logic [IW-1:0] h_wr_data;

   // second write needed on delete, done in two write steps; also marks an insert
   logic wr2_ff, wr2_in;

   kphm_pool u_pool (.clock, .rd_en(p_rd_en), .rd_addr(p_rd_addr), .rd_data(p_rd_data),
      .wr_en(p_wr_en), .wr_addr(p_wr_addr), .wr_data(p_wr_data));
   kphm_heads u_heads (.clock, .reset, .clear(h_clear), .rd_addr(bucket_of(req_word.key)),
      .rd_data(head_q), .wr_en(h_wr_en), .wr_addr(bkt_ff), .wr_data(h_wr_data));

   logic accept;
   logic setval;
   assign accept = start && !busy;
   assign busy = state_ff != S_IDLE;
   assign setval = (req_ff.first_value != '0) || (req_ff.second_value != '0);

   function automatic logic [IW-1:0] lnk(input logic [IW-1:0] l);
      return (l >= NIL_INDEX) ? NIL_INDEX : l;
   endfunction

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      cur_e_in = cur_e_ff;
      prev_e_in = prev_e_ff;
      free_in = free_ff;
      fresh_in = fresh_ff;
      rsp_in = rsp_ff;
      wr2_in = wr2_ff;
      p_rd_en = 1'b0;
      p_rd_addr = AW'(cur_ff);
      p_wr_en = 1'b0;
      p_wr_addr = AW'(cur_ff);
      p_wr_data = cur_e_ff;
      h_wr_en = 1'b0;
      h_wr_data = cur_ff;
      h_clear = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_in = '0;
               rsp_in.status = ST_OK;
               prev_in = NIL_INDEX;
               wr2_in = 1'b0;
               if (req_word.kind == KIND_CLEAR) begin
                  h_clear = 1'b1;
                  free_in = NIL_INDEX;
                  fresh_in = '0;
                  state_in = S_DONE;
               end else if (req_word.kind != KIND_LOOKUP && req_word.kind != KIND_SET) begin
                  state_in = S_DONE;
               end else if (req_word.key == '0) begin
                  rsp_in.status = ST_INVALID;
                  state_in = S_DONE;
               end else begin
                  state_in = S_HEAD;
               end
            end
         end
         S_HEAD: begin
            cur_in = head_q;
            state_in = (head_q < NIL_INDEX) ? S_READ : S_CHECK;
         end
         S_READ: begin
            p_rd_en = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (cur_ff < NIL_INDEX && p_rd_data.key != req_ff.key) begin
               prev_in = cur_ff;
               prev_e_in = p_rd_data;
               cur_in = lnk(p_rd_data.link);
               state_in = (lnk(p_rd_data.link) < NIL_INDEX) ? S_READ : S_CHECK;
               // when moving to nil, re-enter check with cur nil
               if (lnk(p_rd_data.link) >= NIL_INDEX) state_in = S_CHECK;
            end else begin
               if (cur_ff < NIL_INDEX) begin
                  cur_e_in = p_rd_data;
                  rsp_in.found = 1'b1;
                  rsp_in.first_out = p_rd_data.first;
                  rsp_in.second_out = p_rd_data.second;
               end
               if (req_ff.kind == KIND_LOOKUP) state_in = S_DONE;
               else if (setval) state_in = (cur_ff < NIL_INDEX) ? S_WRITE : S_FREE;
               else if (cur_ff < NIL_INDEX) begin
                  wr2_in = 1'b0;
                  state_in = S_WRITE;
               end else state_in = S_DONE;
               if (!(req_ff.kind != KIND_LOOKUP && setval && cur_ff >= NIL_INDEX)
                   && !(req_ff.kind != KIND_LOOKUP && !setval && cur_ff < NIL_INDEX)
                   && !(req_ff.kind != KIND_LOOKUP && setval && cur_ff < NIL_INDEX))
                  state_in = S_DONE;
               if (req_ff.kind != KIND_LOOKUP && setval && cur_ff >= NIL_INDEX)
                  state_in = (free_ff < NIL_INDEX) ? S_READ : S_FREE;
               if (req_ff.kind != KIND_LOOKUP && setval && cur_ff >= NIL_INDEX
                   && free_ff < NIL_INDEX) begin
                  cur_in = free_ff;
                  wr2_in = 1'b1;
                  state_in = S_FREE;
               end
            end
         end
         S_FREE: begin
            // insert: take free list head (its link read issued here) or fresh
            if (wr2_ff && cur_ff < NIL_INDEX && cur_ff == free_ff) begin
               p_rd_en = 1'b1;
               p_rd_addr = AW'(free_ff);
               wr2_in = 1'b0;
               state_in = S_FREE;
               cur_in = NIL_INDEX; // marker: next cycle pops
               prev_e_in.link = free_ff;
            end else if (!wr2_ff && cur_ff >= NIL_INDEX && prev_e_ff.link == free_ff
                         && free_ff < NIL_INDEX) begin
               cur_in = free_ff;
               free_in = lnk(p_rd_data.link);
               cur_e_in = '{key: req_ff.key, first: '0, second: '0, link: '0};
               wr2_in = 1'b1;
               state_in = S_WRITE;
            end else if (fresh_ff < NIL_INDEX) begin
               cur_in = fresh_ff;
               fresh_in = fresh_ff + 1'b1;
               wr2_in = 1'b1;
               state_in = S_WRITE;
            end else begin
               rsp_in.status = ST_NO_ROOM;
               state_in = S_DONE;
            end
         end
         S_WRITE: begin
            if (setval) begin
               p_wr_en = 1'b1;
               p_wr_data.key = req_ff.key;
               p_wr_data.first = req_ff.first_value;
               p_wr_data.second = req_ff.second_value;
               p_wr_data.link = wr2_ff ? bhead_ff : cur_e_ff.link;
               if (wr2_ff) begin
                  h_wr_en = 1'b1;
                  h_wr_data = cur_ff;
               end
               state_in = S_DONE;
            end else if (!wr2_ff) begin
               // unlink from predecessor or head
               if (prev_ff < NIL_INDEX) begin
                  p_wr_en = 1'b1;
                  p_wr_addr = AW'(prev_ff);
                  p_wr_data = prev_e_ff;
                  p_wr_data.link = lnk(cur_e_ff.link);
               end else begin
                  h_wr_en = 1'b1;
                  h_wr_data = lnk(cur_e_ff.link);
               end
               wr2_in = 1'b1;
            end else begin
               p_wr_en = 1'b1;
               p_wr_data = cur_e_ff;
               p_wr_data.link = free_ff;
               free_in = cur_ff;
               state_in = S_DONE;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         free_ff <= NIL_INDEX;
         fresh_ff <= '0;
         strobe_ff <= 1'b0;
         wr2_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         free_ff <= free_in;
         fresh_ff <= fresh_in;
         strobe_ff <= state_ff == S_DONE;
         wr2_ff <= wr2_in;
      end
      if (accept) begin
         req_ff <= req_word;
         bkt_ff <= bucket_of(req_word.key);
      end
      if (state_ff == S_HEAD) bhead_ff <= head_q;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      cur_e_ff <= cur_e_in;
      prev_e_ff <= prev_e_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_word = rsp_ff;
endmodule
`default_nettype wire
